// ===== rtl/fsvm_pkg.sv =====
// ----------------------------------------------------------------------------
// fsvm_pkg: shared constants and types for the SVPWM modulator
// Fixed-point constants, CORDIC arctangent table and inter-stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fsvm_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int DUTY_BITS    = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 16;
	// clamped duty (35 bits) times full scale
	localparam int DUTY_PROD_W  = 35 + DUTY_BITS;

	localparam logic [15:0] BUS_RESET      = 16'd3072;
	localparam logic [33:0] CORDIC_GAIN    = 34'd652032874;
	localparam logic [15:0] LIMIT_Q16      = 16'd56754;
	localparam logic [15:0] NORM_GAIN      = 16'd3;
	localparam logic [39:0] SQRT3_HALF_Q16 = 40'd56756;
	// limit test 9e6*m2 > 2999824*bus^2 reduces to 750^2*m2 > (433*bus)^2
	localparam logic [51:0] LIMIT_M2_K     = 52'd562500;
	localparam logic [24:0] LIMIT_BUS_K    = 25'd433;

	localparam logic [31:0] TURN_MASK =
		~32'((64'd1 << (32 - ANGLE_BITS)) - 64'd1);
	localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};

	localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef logic [DUTY_PROD_W-1:0] duty_prod_t;

	typedef struct packed {
		logic signed [17:0] dn;
		logic signed [17:0] qn;
		logic               lim;
		logic [15:0]        angle;
	} norm_t;

	typedef struct packed {
		logic signed [17:0] dn;
		logic signed [17:0] qn;
		logic               lim;
		logic signed [33:0] sin;
		logic signed [33:0] cos;
	} trig_t;

endpackage

`default_nettype wire

// ===== rtl/fsvm_norm.sv =====
// ----------------------------------------------------------------------------
// fsvm_norm: command normalization and magnitude limit
// Limit test, pipelined integer square root and two pipelined dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module fsvm_norm (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire logic signed [15:0]   volt_d,
	input  wire logic signed [15:0]   volt_q,
	input  wire logic [15:0]          elec_angle,
	input  wire logic [15:0]          bus,
	output logic                      out_vld,
	output fsvm_pkg::norm_t           out
);

	typedef struct packed {
		logic [15:0] absd;
		logic [15:0] absq;
		logic        negd;
		logic        negq;
		logic        lim;
		logic [15:0] angle;
	} side_t;

	logic [15:0]        bus_eff;
	logic signed [31:0] sqd_c, sqq_c;

	assign bus_eff = (bus == 16'd0) ? 16'd1 : bus;
	assign sqd_c   = volt_d * volt_d;
	assign sqq_c   = volt_q * volt_q;

	// limit test stages
	logic        vld_s1, vld_s2, vld_s3;
	side_t       side_s1, side_s2, side_s3;
	logic [31:0] sqd_s1, sqq_s1, m2_s2, m2_s3;
	logic [24:0] p433_s1, p433_s2;
	logic [51:0] lhs_s3;
	logic [49:0] rhs_s3;
	side_t       side_lim;

	always_comb begin
		side_lim     = side_s3;
		side_lim.lim = lhs_s3 > 52'(rhs_s3);
	end

	// square root stages, index 0 holds the limit decision
	logic        vld_sq_s  [0:fsvm_pkg::SQRT_STEPS];
	side_t       side_sq_s [0:fsvm_pkg::SQRT_STEPS];
	logic [31:0] m2_sq_s   [0:fsvm_pkg::SQRT_STEPS];
	logic [35:0] rem_sq_s  [0:fsvm_pkg::SQRT_STEPS];
	logic [31:0] root_sq_s [0:fsvm_pkg::SQRT_STEPS];

	// numerator / denominator prep
	logic        vld_p1;
	side_t       side_p1;
	logic [31:0] prodd_p1, prodq_p1, den_p1;

	// divider stages, index 0 holds the rounded numerators
	logic        vld_dv_s  [0:fsvm_pkg::DIV_STEPS];
	side_t       side_dv_s [0:fsvm_pkg::DIV_STEPS];
	logic [31:0] den_dv_s  [0:fsvm_pkg::DIV_STEPS];
	logic [48:0] remd_dv_s [0:fsvm_pkg::DIV_STEPS];
	logic [48:0] remq_dv_s [0:fsvm_pkg::DIV_STEPS];
	logic [15:0] quod_dv_s [0:fsvm_pkg::DIV_STEPS];
	logic [15:0] quoq_dv_s [0:fsvm_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_sq_s[0]   <= 1'b0;
			vld_p1        <= 1'b0;
			vld_dv_s[0]   <= 1'b0;
			out_vld       <= 1'b0;
		end else if (en) begin
			vld_s1        <= in_vld;
			vld_s2        <= vld_s1;
			vld_s3        <= vld_s2;
			vld_sq_s[0]   <= vld_s3;
			vld_p1        <= vld_sq_s[fsvm_pkg::SQRT_STEPS];
			vld_dv_s[0]   <= vld_p1;
			out_vld       <= vld_dv_s[fsvm_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.absd  <= volt_d[15] ? 16'(-volt_d) : volt_d;
			side_s1.absq  <= volt_q[15] ? 16'(-volt_q) : volt_q;
			side_s1.negd  <= volt_d[15];
			side_s1.negq  <= volt_q[15];
			side_s1.lim   <= 1'b0;
			side_s1.angle <= elec_angle;
			sqd_s1        <= unsigned'(sqd_c);
			sqq_s1        <= unsigned'(sqq_c);
			p433_s1       <= fsvm_pkg::LIMIT_BUS_K * 25'(bus_eff);

			side_s2       <= side_s1;
			m2_s2         <= sqd_s1 + sqq_s1;
			p433_s2       <= p433_s1;

			side_s3       <= side_s2;
			m2_s3         <= m2_s2;
			lhs_s3        <= 52'(m2_s2) * fsvm_pkg::LIMIT_M2_K;
			rhs_s3        <= 50'(p433_s2) * 50'(p433_s2);

			side_sq_s[0]     <= side_lim;
			m2_sq_s[0]       <= m2_s3;
			rem_sq_s[0]      <= '0;
			root_sq_s[0]     <= '0;
		end
	end

	// digit-by-digit root of m2 * 2^32, one result bit per stage
	for (genvar k = 0; k < fsvm_pkg::SQRT_STEPS; k++) begin : g_sqrt
		logic [1:0]  pair;
		logic [35:0] rem_sh, trial;
		logic        take;

		if (k < 16) begin : g_hi
			assign pair = m2_sq_s[k][31-2*k -: 2];
		end else begin : g_lo
			assign pair = 2'b00;
		end

		assign rem_sh = {rem_sq_s[k][33:0], pair};
		assign trial  = {2'b00, root_sq_s[k], 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_sq_s[k+1] <= vld_sq_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sq_s[k+1] <= side_sq_s[k];
				m2_sq_s[k+1]   <= m2_sq_s[k];
				rem_sq_s[k+1]  <= take ? rem_sh - trial : rem_sh;
				root_sq_s[k+1] <= {root_sq_s[k][30:0], take};
			end
		end
	end

	logic [15:0] gain_p;
	assign gain_p = side_sq_s[fsvm_pkg::SQRT_STEPS].lim ? fsvm_pkg::LIMIT_Q16
		: fsvm_pkg::NORM_GAIN;

	always_ff @(posedge clk) begin
		if (en) begin
			side_p1  <= side_sq_s[fsvm_pkg::SQRT_STEPS];
			prodd_p1 <= 32'(side_sq_s[fsvm_pkg::SQRT_STEPS].absd) * 32'(gain_p);
			prodq_p1 <= 32'(side_sq_s[fsvm_pkg::SQRT_STEPS].absq) * 32'(gain_p);
			den_p1   <= side_sq_s[fsvm_pkg::SQRT_STEPS].lim
				? root_sq_s[fsvm_pkg::SQRT_STEPS] : {15'd0, bus_eff, 1'b0};

			// half the divisor added up front rounds half away from zero
			side_dv_s[0] <= side_p1;
			den_dv_s[0]  <= den_p1;
			remd_dv_s[0] <= {1'b0, prodd_p1, 16'd0} + 49'(den_p1[31:1]);
			remq_dv_s[0] <= {1'b0, prodq_p1, 16'd0} + 49'(den_p1[31:1]);
			quod_dv_s[0] <= '0;
			quoq_dv_s[0] <= '0;
		end
	end

	// restoring division, quotient is known to fit 16 bits
	for (genvar k = 0; k < fsvm_pkg::DIV_STEPS; k++) begin : g_div
		logic [48:0] dsh;
		logic        taked, takeq;

		assign dsh   = 49'(den_dv_s[k]) << (fsvm_pkg::DIV_STEPS - 1 - k);
		assign taked = remd_dv_s[k] >= dsh;
		assign takeq = remq_dv_s[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_dv_s[k+1] <= vld_dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_dv_s[k+1] <= side_dv_s[k];
				den_dv_s[k+1]  <= den_dv_s[k];
				remd_dv_s[k+1] <= taked ? remd_dv_s[k] - dsh : remd_dv_s[k];
				remq_dv_s[k+1] <= takeq ? remq_dv_s[k] - dsh : remq_dv_s[k];
				quod_dv_s[k+1] <= {quod_dv_s[k][14:0], taked};
				quoq_dv_s[k+1] <= {quoq_dv_s[k][14:0], takeq};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out.dn    <= side_dv_s[fsvm_pkg::DIV_STEPS].negd
				? -18'(quod_dv_s[fsvm_pkg::DIV_STEPS]) : 18'(quod_dv_s[fsvm_pkg::DIV_STEPS]);
			out.qn    <= side_dv_s[fsvm_pkg::DIV_STEPS].negq
				? -18'(quoq_dv_s[fsvm_pkg::DIV_STEPS]) : 18'(quoq_dv_s[fsvm_pkg::DIV_STEPS]);
			out.lim   <= side_dv_s[fsvm_pkg::DIV_STEPS].lim;
			out.angle <= side_dv_s[fsvm_pkg::DIV_STEPS].angle;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fsvm_cordic.sv =====
// ----------------------------------------------------------------------------
// fsvm_cordic: pipelined sine/cosine
// Rotation CORDIC in Q30, one iteration per stage, half-turn fold at entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fsvm_cordic (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_vld,
	input  wire fsvm_pkg::norm_t in,
	output logic                 out_vld,
	output fsvm_pkg::trig_t      out
);

	logic               vld_s   [0:fsvm_pkg::CORDIC_STEPS];
	fsvm_pkg::norm_t    side_s  [0:fsvm_pkg::CORDIC_STEPS];
	logic               flip_s  [0:fsvm_pkg::CORDIC_STEPS];
	logic signed [33:0] x_s     [0:fsvm_pkg::CORDIC_STEPS];
	logic signed [33:0] y_s     [0:fsvm_pkg::CORDIC_STEPS];
	logic signed [33:0] z_s     [0:fsvm_pkg::CORDIC_STEPS];

	logic [31:0] turn, turn_f;
	logic        flip;

	assign turn   = {in.angle, 16'd0} & fsvm_pkg::TURN_MASK;
	assign flip   = (turn >= 32'h4000_0000) && (turn < 32'hC000_0000);
	assign turn_f = flip ? turn - 32'h8000_0000 : turn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			out_vld  <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			out_vld  <= vld_s[fsvm_pkg::CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in;
			flip_s[0] <= flip;
			x_s[0]    <= signed'(fsvm_pkg::CORDIC_GAIN);
			y_s[0]    <= '0;
			z_s[0]    <= 34'(signed'(turn_f));
		end
	end

	for (genvar k = 0; k < fsvm_pkg::CORDIC_STEPS; k++) begin : g_iter
		logic signed [33:0] xs, ys, at;

		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;
		assign at = signed'(34'(fsvm_pkg::ATAN_TURN32[k]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				flip_s[k+1] <= flip_s[k];
				if (!z_s[k][33]) begin
					x_s[k+1] <= x_s[k] - ys;
					y_s[k+1] <= y_s[k] + xs;
					z_s[k+1] <= z_s[k] - at;
				end else begin
					x_s[k+1] <= x_s[k] + ys;
					y_s[k+1] <= y_s[k] - xs;
					z_s[k+1] <= z_s[k] + at;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out.dn  <= side_s[fsvm_pkg::CORDIC_STEPS].dn;
			out.qn  <= side_s[fsvm_pkg::CORDIC_STEPS].qn;
			out.lim <= side_s[fsvm_pkg::CORDIC_STEPS].lim;
			out.cos <= flip_s[fsvm_pkg::CORDIC_STEPS]
				? -x_s[fsvm_pkg::CORDIC_STEPS] : x_s[fsvm_pkg::CORDIC_STEPS];
			out.sin <= flip_s[fsvm_pkg::CORDIC_STEPS]
				? -y_s[fsvm_pkg::CORDIC_STEPS] : y_s[fsvm_pkg::CORDIC_STEPS];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/foc_svpwm_modulator_top.sv =====
// ----------------------------------------------------------------------------
// foc_svpwm_modulator_top: inverse Park / Clarke space-vector modulator
//
//   channel   signals                                      flow
//   cmd       cmd_valid cmd_stall volt_d volt_q elec_angle in
//   duty      duty_valid duty_stall duty_phase_a/b/c        out
//             magnitude_limited
//   cfg       cfg_wr_en cfg_wr_data (bus_voltage)           in
//
// One request per cycle while cmd_stall is low; the 32-stage root, the
// 16-stage dividers and the 24-stage CORDIC run in series.
// Reset clears all valid bits; bus_voltage resets to 12 V.
// When duty_valid is high and duty_stall is high the whole pipe holds and
// cmd_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_svpwm_modulator_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic signed [15:0] volt_d,
	input  wire logic signed [15:0] volt_q,
	input  wire logic [15:0]        elec_angle,
	output logic                    duty_valid,
	input  wire logic               duty_stall,
	output logic [15:0]             duty_phase_a,
	output logic [15:0]             duty_phase_b,
	output logic [15:0]             duty_phase_c,
	output logic                    magnitude_limited,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data
);

	function automatic logic signed [19:0] rnd30(input logic signed [52:0] v);
		logic [52:0] mag, q;
		mag = v[52] ? 53'(-v) : 53'(v);
		q   = (mag + (53'd1 << 29)) >> 30;
		return v[52] ? -20'(q) : 20'(q);
	endfunction

	function automatic logic [34:0] clamp_d(input logic signed [41:0] d);
		logic [34:0] r;
		if (d[41])
			r = '0;
		else if (d > 42'sd17179869184)
			r = 35'd17179869184;
		else
			r = d[34:0];
		return r;
	endfunction

	logic [15:0] bus_q;
	logic        en;

	assign en        = !(duty_valid && duty_stall);
	assign cmd_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= fsvm_pkg::BUS_RESET;
		end else if (cfg_wr_en) begin
			bus_q <= cfg_wr_data;
		end
	end

	logic            nrm_vld, trg_vld;
	fsvm_pkg::norm_t nrm;
	fsvm_pkg::trig_t trg;

	fsvm_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (cmd_valid),
		.volt_d     (volt_d),
		.volt_q     (volt_q),
		.elec_angle (elec_angle),
		.bus        (bus_q),
		.out_vld    (nrm_vld),
		.out        (nrm)
	);

	fsvm_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (nrm_vld),
		.in      (nrm),
		.out_vld (trg_vld),
		.out     (trg)
	);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic lim_s1, lim_s2, lim_s3, lim_s4, lim_s5, lim_s6, lim_s7, lim_s8;

	logic signed [51:0]   dc_s1, qs_s1, ds_s1, qc_s1;
	logic signed [52:0]   sa_s2, sb_s2;
	logic signed [19:0]   alpha_s3, beta_s3;
	logic signed [39:0]   ua_s4, ah_s4, tb_s4;
	logic signed [39:0]   ua_s5, ub_s5, uc_s5;
	logic signed [39:0]   ua_s6, ub_s6, uc_s6, mx_s6, mn_s6;
	logic [34:0]          da_s7, db_s7, dc_s7;
	fsvm_pkg::duty_prod_t pa_s8, pb_s8, pc_s8;

	logic signed [39:0]   mx_ab, mn_ab;
	logic signed [41:0]   sum_mm;
	fsvm_pkg::duty_prod_t ra, rb, rc;

	assign mx_ab  = (ua_s5 > ub_s5) ? ua_s5 : ub_s5;
	assign mn_ab  = (ua_s5 < ub_s5) ? ua_s5 : ub_s5;
	assign sum_mm = 42'(mx_s6) + 42'(mn_s6) - (42'sd1 <<< 33);
	assign ra     = pa_s8 + (fsvm_pkg::duty_prod_t'(1) << 33);
	assign rb     = pb_s8 + (fsvm_pkg::duty_prod_t'(1) << 33);
	assign rc     = pc_s8 + (fsvm_pkg::duty_prod_t'(1) << 33);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			vld_s8     <= 1'b0;
			duty_valid <= 1'b0;
		end else if (en) begin
			vld_s1     <= trg_vld;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			vld_s7     <= vld_s6;
			vld_s8     <= vld_s7;
			duty_valid <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// inverse Park
			lim_s1   <= trg.lim;
			dc_s1    <= trg.dn * trg.cos;
			qs_s1    <= trg.qn * trg.sin;
			ds_s1    <= trg.dn * trg.sin;
			qc_s1    <= trg.qn * trg.cos;

			lim_s2   <= lim_s1;
			sa_s2    <= 53'(dc_s1) - 53'(qs_s1);
			sb_s2    <= 53'(ds_s1) + 53'(qc_s1);

			lim_s3   <= lim_s2;
			alpha_s3 <= rnd30(sa_s2);
			beta_s3  <= rnd30(sb_s2);

			// inverse Clarke, Q32
			lim_s4   <= lim_s3;
			ua_s4    <= 40'(alpha_s3) <<< 16;
			ah_s4    <= 40'(alpha_s3) <<< 15;
			tb_s4    <= signed'(fsvm_pkg::SQRT3_HALF_Q16) * 40'(beta_s3);

			lim_s5   <= lim_s4;
			ua_s5    <= ua_s4;
			ub_s5    <= tb_s4 - ah_s4;
			uc_s5    <= -ah_s4 - tb_s4;

			// min-max injection
			lim_s6   <= lim_s5;
			ua_s6    <= ua_s5;
			ub_s6    <= ub_s5;
			uc_s6    <= uc_s5;
			mx_s6    <= (mx_ab > uc_s5) ? mx_ab : uc_s5;
			mn_s6    <= (mn_ab < uc_s5) ? mn_ab : uc_s5;

			lim_s7   <= lim_s6;
			da_s7    <= clamp_d((42'(ua_s6) <<< 1) - sum_mm);
			db_s7    <= clamp_d((42'(ub_s6) <<< 1) - sum_mm);
			dc_s7    <= clamp_d((42'(uc_s6) <<< 1) - sum_mm);

			lim_s8   <= lim_s7;
			pa_s8    <= fsvm_pkg::duty_prod_t'(da_s7)
				* fsvm_pkg::duty_prod_t'(fsvm_pkg::DUTY_FULL);
			pb_s8    <= fsvm_pkg::duty_prod_t'(db_s7)
				* fsvm_pkg::duty_prod_t'(fsvm_pkg::DUTY_FULL);
			pc_s8    <= fsvm_pkg::duty_prod_t'(dc_s7)
				* fsvm_pkg::duty_prod_t'(fsvm_pkg::DUTY_FULL);

			magnitude_limited <= lim_s8;
			duty_phase_a      <= 16'(ra[34 +: fsvm_pkg::DUTY_BITS]);
			duty_phase_b      <= 16'(rb[34 +: fsvm_pkg::DUTY_BITS]);
			duty_phase_c      <= 16'(rc[34 +: fsvm_pkg::DUTY_BITS]);
		end
	end

endmodule

`default_nettype wire

// ===== bench/foc_svpwm_modulator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_svpwm_modulator_top_test: self-checking bench for the SVPWM modulator
// Drives voltage commands through a table of directed cases and then random
// ones over several bus settings. Expected duties come from typed rows or a
// bit-exact fixed-point predictor; each accepted output is compared to them.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_svpwm_modulator_top_test;

	localparam int  LATENCY    = 90;
	localparam int  N_RANDOM   = 1200;
	localparam int  CYCLE_MAX  = 400000;
	localparam logic [63:0] LIM_Q16  = 64'd56754;
	localparam logic [63:0] SQ3_Q16  = 64'd56756;

	typedef struct {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic        lim;
	} duty_t;

	typedef struct {
		logic signed [15:0] vd;
		logic signed [15:0] vq;
		logic [15:0]        ang;
		bit                 typed;
		logic [15:0]        a;
		logic [15:0]        b;
		logic [15:0]        c;
		logic               lim;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic signed [15:0] volt_d = '0;
	logic signed [15:0] volt_q = '0;
	logic [15:0] elec_angle = '0;
	logic duty_valid;
	logic duty_stall = 1'b0;
	logic [15:0] duty_phase_a, duty_phase_b, duty_phase_c;
	logic magnitude_limited;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	logic [15:0] bus_setting;
	duty_t duty_queue[$];
	int mismatches = 0;
	int checked = 0;
	int limited_seen = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit done_driving = 1'b0;

	foc_svpwm_modulator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.volt_d(volt_d), .volt_q(volt_q), .elec_angle(elec_angle),
		.duty_valid(duty_valid), .duty_stall(duty_stall),
		.duty_phase_a(duty_phase_a), .duty_phase_b(duty_phase_b),
		.duty_phase_c(duty_phase_c), .magnitude_limited(magnitude_limited),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint div_half_up(longint n, longint d);
		longint m, q;
		m = (n < 0) ? -n : n;
		q = (m + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic logic [15:0] phase_duty(longint u, longint mx, longint mn);
		longint d;
		longint unsigned p;
		d = 2 * u - (mx + mn) + (64'sd1 << 33);
		if (d < 0) d = 0;
		if (d > (64'sd1 << 34)) d = 64'sd1 << 34;
		p = (longint'(d) * 65535 + (64'd1 << 33)) >> 34;
		return p[15:0];
	endfunction

	function automatic duty_t svpwm_duty(logic signed [15:0] vd_in,
			logic signed [15:0] vq_in, logic [15:0] ang, logic [15:0] bus_reg);
		duty_t r;
		longint vd, vq, bus, m2, dn, qn, z, x, y, nx, s, c, al, be, ua, ub, uc, mx, mn;
		longint unsigned mag;
		logic [31:0] t;
		bit flip;
		vd = vd_in;
		vq = vq_in;
		bus = (bus_reg == 0) ? 1 : bus_reg;
		m2 = vd * vd + vq * vq;
		r.lim = (64'd9000000 * m2) > (64'd2999824 * bus * bus);
		if (r.lim) begin
			mag = int_sqrt(longint'(m2) << 32);
			dn = div_half_up(vd * longint'(LIM_Q16) * 65536, mag);
			qn = div_half_up(vq * longint'(LIM_Q16) * 65536, mag);
		end else begin
			dn = div_half_up(3 * vd * 65536, 2 * bus);
			qn = div_half_up(3 * vq * 65536, 2 * bus);
		end
		t = {ang, 16'h0};
		flip = 1'b0;
		if (t >= 32'h40000000 && t < 32'hC0000000) begin
			t = t - 32'h80000000;
			flip = 1'b1;
		end
		z = longint'($signed(t));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= longint'(fsvm_pkg::ATAN_TURN32[i]);
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += longint'(fsvm_pkg::ATAN_TURN32[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		al = div_half_up(dn * c - qn * s, 64'sd1 << 30);
		be = div_half_up(dn * s + qn * c, 64'sd1 << 30);
		ua = al * 65536;
		ub = -al * 32768 + longint'(SQ3_Q16) * be;
		uc = -al * 32768 - longint'(SQ3_Q16) * be;
		mx = (ua > ub) ? ua : ub;
		mx = (mx > uc) ? mx : uc;
		mn = (ua < ub) ? ua : ub;
		mn = (mn < uc) ? mn : uc;
		r.a = phase_duty(ua, mx, mn);
		r.b = phase_duty(ub, mx, mn);
		r.c = phase_duty(uc, mx, mn);
		return r;
	endfunction

	// directed table; typed rows are readable at a glance
	row_t dir_rows[] = '{
		'{16'sd0, 16'sd0, 16'h0000, 1'b1, 16'd32768, 16'd32768, 16'd32768, 1'b0},
		'{16'sd0, 16'sd0, 16'hFFFF, 1'b1, 16'd32768, 16'd32768, 16'd32768, 1'b0},
		'{16'sh7FFF, 16'sh7FFF, 16'h0000, 1'b0, 0, 0, 0, 0},
		'{-16'sd32768, -16'sd32768, 16'h8000, 1'b0, 0, 0, 0, 0},
		'{16'sh7FFF, -16'sd32768, 16'h4000, 1'b0, 0, 0, 0, 0},
		'{-16'sd32768, 16'sh7FFF, 16'hC000, 1'b0, 0, 0, 0, 0},
		'{16'sd256, 16'sd0, 16'h0000, 1'b0, 0, 0, 0, 0},
		'{16'sd0, 16'sd1024, 16'h2AAA, 1'b0, 0, 0, 0, 0},
		'{16'sd1, 16'sd0, 16'h3FFF, 1'b0, 0, 0, 0, 0},
		'{-16'sd1, 16'sd0, 16'hBFFF, 1'b0, 0, 0, 0, 0},
		'{16'sd1772, 16'sd0, 16'h1555, 1'b0, 0, 0, 0, 0},
		'{16'sd1774, 16'sd0, 16'h5555, 1'b0, 0, 0, 0, 0},
		'{16'sd0, -16'sd1773, 16'hAAAA, 1'b0, 0, 0, 0, 0},
		'{16'sh5555, 16'shAAAA, 16'h0001, 1'b0, 0, 0, 0, 0},
		'{16'shAAAA, 16'sh5555, 16'hFFFE, 1'b0, 0, 0, 0, 0}
	};

	// result side: stall at random, compare with oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) duty_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
		if (arst_n && duty_valid && !duty_stall) begin
			duty_t e;
			if (duty_queue.size() == 0) begin
				$display("%0t: unexpected duty a=%0d b=%0d c=%0d lim=%0b", $time,
					duty_phase_a, duty_phase_b, duty_phase_c, magnitude_limited);
				mismatches <= mismatches + 1;
			end else begin
				e = duty_queue.pop_front();
				checked <= checked + 1;
				if (magnitude_limited) limited_seen <= limited_seen + 1;
				if (e.a !== duty_phase_a || e.b !== duty_phase_b ||
						e.c !== duty_phase_c || e.lim !== magnitude_limited) begin
					$display("%0t: mismatch expected a=%0d b=%0d c=%0d lim=%0b",
						$time, e.a, e.b, e.c, e.lim);
					$display("%0t:          actual   a=%0d b=%0d c=%0d lim=%0b",
						$time, duty_phase_a, duty_phase_b, duty_phase_c,
						magnitude_limited);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	task automatic send_cmd(logic signed [15:0] vd, logic signed [15:0] vq,
			logic [15:0] ang, bit typed, duty_t typed_duty);
		while (!calm && $urandom_range(99) < 16) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		volt_d <= vd;
		volt_q <= vq;
		elec_angle <= ang;
		duty_queue.push_back(typed ? typed_duty : svpwm_duty(vd, vq, ang, bus_setting));
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic set_bus(logic [15:0] v);
		cmd_valid <= 1'b0;
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bus_setting = v;
	endtask

	task automatic random_cmd(logic [15:0] bus_reg);
		logic signed [15:0] vd, vq;
		logic [15:0] span;
		duty_t nil;
		nil = '{default: 0};
		span = (bus_reg > 16'd16383) ? 16'd32767 : 16'(bus_reg * 2 + 1);
		case ($urandom_range(3))
			0: begin
				vd = $urandom;
				vq = $urandom;
			end
			default: begin
				// mostly near the limit circle so both branches show up
				vd = $signed(16'($urandom_range(span))) - $signed(16'(span / 2));
				vq = $signed(16'($urandom_range(span))) - $signed(16'(span / 2));
			end
		endcase
		send_cmd(vd, vq, 16'($urandom), 1'b0, nil);
	endtask

	initial begin
		logic [15:0] buses[5];
		duty_t td;
		buses = '{16'd3072, 16'd1, 16'd65535, 16'd0, 16'd512};
		bus_setting = fsvm_pkg::BUS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			td = '{dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].lim};
			send_cmd(dir_rows[i].vd, dir_rows[i].vq, dir_rows[i].ang,
				dir_rows[i].typed, td);
		end
		for (int p = 0; p < 5; p++) begin
			set_bus(buses[p]);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				calm = (p == 2 && n >= 60 && n < 160);
				random_cmd(bus_setting);
			end
		end
		calm = 1'b0;
		cmd_valid <= 1'b0;
		done_driving = 1'b1;
	end

	initial begin
		wait (done_driving);
		while (duty_queue.size() != 0 && cycles < CYCLE_MAX) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (cycles >= CYCLE_MAX || duty_queue.size() != 0) begin
			$display("timeout or leftover expectations: %0d", duty_queue.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			$display("covered %0d duty results, %0d of them magnitude limited,",
				checked, limited_seen);
			$display("over five bus voltage settings including 0, 1 and 65535");
			if (mismatches == 0) begin
				$display("end of test: clean");
			end else begin
				$display("end of test: mismatches");
			end
			$finish;
		end
	end

	initial begin
		wait (cycles >= CYCLE_MAX);
		$display("run exceeded cycle limit");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

// ===== foc_svpwm_modulator_top.f =====
rtl/fsvm_pkg.sv
rtl/fsvm_norm.sv
rtl/fsvm_cordic.sv
rtl/foc_svpwm_modulator_top.sv
bench/foc_svpwm_modulator_top_test.sv
